### rtl/core/gbi_pkg.sv
// Package for the GPIO bank core: sizes, register and request codes,
// pin type codes and the request and result structs.
// Depends on nothing; the RTL files use it by scoped names, the testbench imports it.
package gbi_pkg;

   localparam int NumPins   = 32;
   localparam int WordWidth = 32;
   localparam int CtlWidth  = 5;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [1:0]           req_code_type;
   typedef logic [2:0]           reg_index_type;
   typedef logic [CtlWidth-1:0]  ctl_type;
   typedef logic [1:0]           pin_kind_type;

   // Per-pin register bits above the bank width are held at zero.
   localparam word_type PinMask = WordWidth'((64'd1 << NumPins) - 64'd1);

   localparam req_code_type ReqRead   = 2'd0;
   localparam req_code_type ReqWrite  = 2'd1;
   localparam req_code_type ReqSample = 2'd2;

   localparam reg_index_type RegOutEnable = 3'd0;
   localparam reg_index_type RegInEnable  = 3'd1;
   localparam reg_index_type RegData      = 3'd2;
   localparam reg_index_type RegPending   = 3'd3;
   localparam reg_index_type RegMask      = 3'd4;
   localparam reg_index_type RegTypeUpper = 3'd5;
   localparam reg_index_type RegTypeLower = 3'd6;
   localparam reg_index_type RegControl   = 3'd7;

   localparam int CtlPending = 0;
   localparam int CtlEnable  = 1;

   localparam pin_kind_type KindHigh = 2'd0;
   localparam pin_kind_type KindLow  = 2'd1;
   localparam pin_kind_type KindRise = 2'd2;
   localparam pin_kind_type KindFall = 2'd3;

   typedef struct packed {
      req_code_type  req_type;
      reg_index_type reg_index;
      word_type      write_data;
      word_type      pin_levels;
   } request_type;

   typedef struct packed {
      word_type read_data;
      word_type pin_drive;
      word_type pin_drive_enable;
      logic     irq_out;
   } result_type;

endpackage

### rtl/core/gbi_channels.sv
// Valid/ready channel interfaces for requests and results of the GPIO bank.
// Depends on gbi_pkg for the field widths.
interface gbi_req_if;
   logic                   valid;
   logic                   ready;
   gbi_pkg::req_code_type  req_type;
   gbi_pkg::reg_index_type reg_index;
   gbi_pkg::word_type      write_data;
   gbi_pkg::word_type      pin_levels;

   modport source(output valid, req_type, reg_index, write_data, pin_levels, input ready);
   modport sink(input valid, req_type, reg_index, write_data, pin_levels, output ready);
endinterface

interface gbi_rsp_if;
   logic              valid;
   logic              ready;
   gbi_pkg::word_type read_data;
   gbi_pkg::word_type pin_drive;
   gbi_pkg::word_type pin_drive_enable;
   logic              irq_out;

   modport source(output valid, read_data, pin_drive, pin_drive_enable, irq_out, input ready);
   modport sink(input valid, read_data, pin_drive, pin_drive_enable, irq_out, output ready);
endinterface

### rtl/core/gbi_sample.sv
// Per-pin interrupt detector: level high/low and rising/falling edge hits.
// Depends on gbi_pkg; purely combinational.
module gbi_sample (
   input  gbi_pkg::word_type type_lower,
   input  gbi_pkg::word_type type_upper,
   input  gbi_pkg::word_type pads,
   input  gbi_pkg::word_type prev_pads,
   output gbi_pkg::word_type hits
);

   always_comb begin
      gbi_pkg::pin_kind_type kind;
      hits = '0;
      kind = gbi_pkg::KindHigh;
      for (int i = 0; i < gbi_pkg::NumPins; i++) begin
         // The lower type word covers pins 0-15, the upper one pins 16-31.
         if (i < 16) begin
            kind = type_lower[2*i +: 2];
         end else begin
            kind = type_upper[2*(i-16) +: 2];
         end
         case (kind)
            gbi_pkg::KindHigh: hits[i] = pads[i];
            gbi_pkg::KindLow:  hits[i] = ~pads[i];
            gbi_pkg::KindRise: hits[i] = pads[i] & ~prev_pads[i];
            gbi_pkg::KindFall: hits[i] = prev_pads[i] & ~pads[i];
            default:           hits[i] = 1'b0;
         endcase
      end
   end

endmodule

### rtl/core/gbi_regs.sv
// Register block of the GPIO bank: applies one request to the bank state
// and forms its result. Depends on gbi_pkg and gbi_sample.
module gbi_regs (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 process,
   input  gbi_pkg::request_type req,
   output gbi_pkg::result_type  rsp
);

   gbi_pkg::word_type out_en_ff, out_en_in;
   gbi_pkg::word_type in_en_ff, in_en_in;
   gbi_pkg::word_type data_ff, data_in;
   gbi_pkg::word_type pend_ff, pend_in;
   gbi_pkg::word_type mask_ff, mask_in;
   gbi_pkg::word_type type_upper_ff, type_upper_in;
   gbi_pkg::word_type type_lower_ff, type_lower_in;
   gbi_pkg::ctl_type  ctl_ff, ctl_in;
   gbi_pkg::word_type prev_ff, prev_in;
   gbi_pkg::word_type hits;
   gbi_pkg::word_type read_data;

   gbi_sample u_sample (
      .type_lower (type_lower_ff),
      .type_upper (type_upper_ff),
      .pads       (req.pin_levels),
      .prev_pads  (prev_ff),
      .hits       (hits)
   );

   always_comb begin
      out_en_in     = out_en_ff;
      in_en_in      = in_en_ff;
      data_in       = data_ff;
      pend_in       = pend_ff;
      mask_in       = mask_ff;
      type_upper_in = type_upper_ff;
      type_lower_in = type_lower_ff;
      ctl_in        = ctl_ff;
      prev_in       = prev_ff;
      read_data     = '0;
      if (process) begin
         case (req.req_type)
            gbi_pkg::ReqRead: begin
               case (req.reg_index)
                  gbi_pkg::RegOutEnable: read_data = out_en_ff;
                  gbi_pkg::RegInEnable:  read_data = in_en_ff;
                  gbi_pkg::RegData: begin
                     read_data = (data_ff & out_en_ff) |
                                 (req.pin_levels & in_en_ff & ~out_en_ff & gbi_pkg::PinMask);
                  end
                  gbi_pkg::RegPending:   read_data = pend_ff;
                  gbi_pkg::RegMask:      read_data = mask_ff;
                  gbi_pkg::RegTypeUpper: read_data = type_upper_ff;
                  gbi_pkg::RegTypeLower: read_data = type_lower_ff;
                  default:               read_data = {{(gbi_pkg::WordWidth-gbi_pkg::CtlWidth){1'b0}},
                                                      ctl_ff};
               endcase
            end
            gbi_pkg::ReqWrite: begin
               case (req.reg_index)
                  gbi_pkg::RegOutEnable: out_en_in = req.write_data & gbi_pkg::PinMask;
                  gbi_pkg::RegInEnable:  in_en_in = req.write_data & gbi_pkg::PinMask;
                  gbi_pkg::RegData:      data_in = req.write_data & gbi_pkg::PinMask;
                  gbi_pkg::RegPending:   pend_in = pend_ff & ~req.write_data;
                  gbi_pkg::RegMask:      mask_in = req.write_data & gbi_pkg::PinMask;
                  gbi_pkg::RegTypeUpper: type_upper_in = req.write_data;
                  gbi_pkg::RegTypeLower: type_lower_in = req.write_data;
                  default: begin
                     // Bank pending is write-one-to-clear; the other bits are stored.
                     ctl_in = {req.write_data[gbi_pkg::CtlWidth-1:1],
                               ctl_ff[gbi_pkg::CtlPending] & ~req.write_data[0]};
                  end
               endcase
            end
            gbi_pkg::ReqSample: begin
               if ((hits & ~pend_ff & mask_ff) != '0) begin
                  ctl_in[gbi_pkg::CtlPending] = 1'b1;
               end
               pend_in = pend_ff | hits;
               prev_in = req.pin_levels;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_en_ff     <= '0;
         in_en_ff      <= '0;
         data_ff       <= '0;
         pend_ff       <= '0;
         mask_ff       <= '0;
         type_upper_ff <= '0;
         type_lower_ff <= '0;
         ctl_ff        <= '0;
         prev_ff       <= '0;
      end else begin
         out_en_ff     <= out_en_in;
         in_en_ff      <= in_en_in;
         data_ff       <= data_in;
         pend_ff       <= pend_in;
         mask_ff       <= mask_in;
         type_upper_ff <= type_upper_in;
         type_lower_ff <= type_lower_in;
         ctl_ff        <= ctl_in;
         prev_ff       <= prev_in;
      end
   end

   // The result reflects the state after this request.
   assign rsp.read_data        = read_data;
   assign rsp.pin_drive        = data_in & out_en_in;
   assign rsp.pin_drive_enable = out_en_in;
   assign rsp.irq_out          = ctl_in[gbi_pkg::CtlEnable] && ((pend_in & mask_in) != '0);

   assert property (@(posedge clock) disable iff (reset)
      !(process && req.req_type == gbi_pkg::ReqSample) |=> !$rose(ctl_ff[gbi_pkg::CtlPending]))
      else $error("bank pending set without a pin sample");

   assert property (@(posedge clock) disable iff (reset)
      !(process && req.req_type == gbi_pkg::ReqSample) |=> ((pend_ff & ~$past(pend_ff)) == '0))
      else $error("pin pending bit set without a pin sample");

   assert property (@(posedge clock) disable iff (reset)
      !process |=> $stable(pend_ff) && $stable(ctl_ff) && $stable(out_en_ff))
      else $error("bank state changed with no request in process");

endmodule

### rtl/core/gpio_bank_with_interrupts_core.sv
// GPIO bank core: 32-pin register block with edge and level interrupts.
// A request is registered in the input stage, then its result in the output stage once that is free or draining.
// Throughput: one request per cycle while results are taken, set by the single register-block pass.
// Reset is synchronous and clears all bank registers and both stages at once.
// Depends on gbi_pkg, gbi_channels and gbi_regs.
module gpio_bank_with_interrupts_core (
   input logic      clock,
   input logic      reset,
   gbi_req_if.sink  req_chan,
   gbi_rsp_if.source rsp_chan
);

   logic                 in_valid_ff, in_valid_in;
   gbi_pkg::request_type in_ff, in_in;
   logic                 out_valid_ff, out_valid_in;
   gbi_pkg::result_type  out_ff, out_in;
   gbi_pkg::result_type  result;
   logic                 process;
   logic                 req_take;

   // The staged request goes through when the result register is free or draining.
   assign process        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || process;
   assign req_take       = req_chan.valid && req_chan.ready;

   gbi_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .process (process),
      .req     (in_ff),
      .rsp     (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_in        = in_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (process) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in       = 1'b1;
         in_in.req_type    = req_chan.req_type;
         in_in.reg_index   = req_chan.reg_index;
         in_in.write_data  = req_chan.write_data;
         in_in.pin_levels  = req_chan.pin_levels;
      end
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (process) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.read_data        = out_ff.read_data;
   assign rsp_chan.pin_drive        = out_ff.pin_drive;
   assign rsp_chan.pin_drive_enable = out_ff.pin_drive_enable;
   assign rsp_chan.irq_out          = out_ff.irq_out;

   assert property (@(posedge clock) disable iff (reset)
      process |=> out_valid_ff)
      else $error("processed request produced no result");

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |=> in_valid_ff && $stable(in_ff))
      else $error("staged request lost or changed while waiting");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> out_valid_ff && $stable(out_ff))
      else $error("waiting result lost or changed while stalled");

endmodule

### verif/gpio_bank_with_interrupts_core_test.sv
// Self-checking testbench for the GPIO bank core: register accesses and pin samples
// are checked against a bank model kept by a small scoreboard class.
// Depends on gbi_pkg, gbi_channels and the gpio_bank_with_interrupts_core RTL.
`timescale 1ns / 1ps

import gbi_pkg::*;

class gpio_bank_tracker;
   word_type   out_enable;
   word_type   in_enable;
   word_type   data_latch;
   word_type   pending;
   word_type   intr_mask;
   word_type   type_upper;
   word_type   type_lower;
   word_type   last_levels;
   ctl_type    control;
   result_type awaited[$];
   int         error_count;

   function new();
      out_enable  = '0;
      in_enable   = '0;
      data_latch  = '0;
      pending     = '0;
      intr_mask   = '0;
      type_upper  = '0;
      type_lower  = '0;
      last_levels = '0;
      control     = '0;
      error_count = 0;
   endfunction

   task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Applies one accepted request to the bank and queues the result it must give.
   function void note_request(request_type r);
      result_type   want;
      word_type     hits;
      pin_kind_type kind;
      want.read_data = '0;
      case (r.req_type)
         ReqRead: begin
            case (r.reg_index)
               RegOutEnable: want.read_data = out_enable;
               RegInEnable:  want.read_data = in_enable;
               RegData:      want.read_data = (data_latch & out_enable) |
                                              (r.pin_levels & in_enable & ~out_enable & PinMask);
               RegPending:   want.read_data = pending;
               RegMask:      want.read_data = intr_mask;
               RegTypeUpper: want.read_data = type_upper;
               RegTypeLower: want.read_data = type_lower;
               default:      want.read_data = word_type'(control);
            endcase
         end
         ReqWrite: begin
            case (r.reg_index)
               RegOutEnable: out_enable = r.write_data & PinMask;
               RegInEnable:  in_enable  = r.write_data & PinMask;
               RegData:      data_latch = r.write_data & PinMask;
               RegPending:   pending    = pending & ~r.write_data;
               RegMask:      intr_mask  = r.write_data & PinMask;
               RegTypeUpper: type_upper = r.write_data;
               RegTypeLower: type_lower = r.write_data;
               default: begin
                  // The bank pending bit is write-one-to-clear; the rest is stored as written.
                  control[CtlWidth-1:1] = r.write_data[CtlWidth-1:1];
                  control[CtlPending]   = control[CtlPending] & ~r.write_data[CtlPending];
               end
            endcase
         end
         ReqSample: begin
            hits = '0;
            for (int i = 0; i < WordWidth; i++) begin
               kind = (i < 16) ? type_lower[(i % 16) * 2 +: 2] : type_upper[(i % 16) * 2 +: 2];
               case (kind)
                  KindHigh: hits[i] = r.pin_levels[i];
                  KindLow:  hits[i] = ~r.pin_levels[i];
                  KindRise: hits[i] = r.pin_levels[i] & ~last_levels[i];
                  default:  hits[i] = last_levels[i] & ~r.pin_levels[i];
               endcase
            end
            hits &= PinMask;
            // Only a newly pending pin that is unmasked raises the bank pending bit.
            if ((hits & ~pending & intr_mask) != '0) control[CtlPending] = 1'b1;
            pending     = pending | hits;
            last_levels = r.pin_levels;
         end
         default: ;
      endcase
      want.pin_drive        = data_latch & out_enable;
      want.pin_drive_enable = out_enable;
      want.irq_out          = control[CtlEnable] && ((pending & intr_mask) != '0);
      awaited.push_back(want);
   endfunction

   task check_result(result_type got);
      result_type want;
      if (awaited.size() == 0) begin
         report($sformatf("result with no request outstanding, read_data %h", got.read_data));
         return;
      end
      want = awaited.pop_front();
      if (got.read_data !== want.read_data)
         report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
      if (got.pin_drive !== want.pin_drive)
         report($sformatf("pin_drive %h, want %h", got.pin_drive, want.pin_drive));
      if (got.pin_drive_enable !== want.pin_drive_enable)
         report($sformatf("pin_drive_enable %h, want %h",
                          got.pin_drive_enable, want.pin_drive_enable));
      if (got.irq_out !== want.irq_out)
         report($sformatf("irq_out %b, want %b", got.irq_out, want.irq_out));
   endtask
endclass

module gpio_bank_with_interrupts_core_test;

   localparam req_code_type ReqUnused   = 2'd3;
   localparam int           RandomItems = 450;
   localparam int           HoldAt      = 150;
   localparam int           HoldItems   = 60;
   localparam int           DrainAt     = 300;
   localparam int           LongHold    = 200;

   typedef enum {RxFree, RxMostly, RxSparse, RxPeriodic} rx_mode_type;

   logic clock;
   logic reset;
   int   holds_asked;

   request_type seen_req;
   result_type  seen_rsp;

   gpio_bank_tracker tracker = new();

   gbi_req_if req_chan();
   gbi_rsp_if rsp_chan();

   gpio_bank_with_interrupts_core dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic request_type bus_request(req_code_type code, reg_index_type idx,
                                               word_type wd, word_type pads);
      request_type r;
      r.req_type   = code;
      r.reg_index  = idx;
      r.write_data = wd;
      r.pin_levels = pads;
      return r;
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(0, WordWidth - 1);
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type make_random_request();
      request_type r;
      int          pick;
      pick = $urandom_range(0, 99);
      r.req_type   = (pick < 35) ? ReqRead : (pick < 70) ? ReqWrite :
                     (pick < 96) ? ReqSample : ReqUnused;
      r.reg_index  = reg_index_type'($urandom_range(0, 7));
      r.write_data = rand_word();
      r.pin_levels = rand_word();
      // Keep the bank enabled most of the time so that pending pins reach irq.
      if (r.req_type == ReqWrite && r.reg_index == RegControl)
         r.write_data[CtlEnable] = ($urandom_range(0, 9) < 7);
      return r;
   endfunction

   task automatic send_request(input request_type r);
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= r.req_type;
      req_chan.reg_index  <= r.reg_index;
      req_chan.write_data <= r.write_data;
      req_chan.pin_levels <= r.pin_levels;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic idle_cycles(input int n);
      req_chan.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (tracker.awaited.size() != 0);
   endtask

   // Every accepted request and result is seen here, before the edge's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready === 1'b1) begin
            seen_req.req_type   = req_chan.req_type;
            seen_req.reg_index  = req_chan.reg_index;
            seen_req.write_data = req_chan.write_data;
            seen_req.pin_levels = req_chan.pin_levels;
            tracker.note_request(seen_req);
         end
         if ($isunknown(rsp_chan.valid)) begin
            tracker.report("result valid is unknown");
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            seen_rsp.read_data        = rsp_chan.read_data;
            seen_rsp.pin_drive        = rsp_chan.pin_drive;
            seen_rsp.pin_drive_enable = rsp_chan.pin_drive_enable;
            seen_rsp.irq_out          = rsp_chan.irq_out;
            tracker.check_result(seen_rsp);
         end
      end
   end

   // Result side: segments of differing stall patterns, plus long hold-offs on demand.
   initial begin
      int          seg_left;
      int          phase_count;
      int          holds_done;
      int          hold_left;
      rx_mode_type mode;
      seg_left    = 0;
      phase_count = 0;
      holds_done  = 0;
      hold_left   = 0;
      mode        = RxFree;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (holds_asked != holds_done) begin
            holds_done++;
            hold_left = LongHold - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               mode     = rx_mode_type'($urandom_range(0, 3));
               seg_left = $urandom_range(8, 60);
            end
            seg_left--;
            phase_count++;
            case (mode)
               RxFree:   rsp_chan.ready <= 1'b1;
               RxMostly: rsp_chan.ready <= ($urandom_range(0, 9) < 7);
               RxSparse: rsp_chan.ready <= ($urandom_range(0, 9) < 3);
               default:  rsp_chan.ready <= (phase_count % 4 != 0);
            endcase
         end
         @(posedge clock);
      end
   end

   initial begin
      #200000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int burst_left;
      int steady_left;
      burst_left  = 0;
      steady_left = 0;
      holds_asked <= 0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= ReqRead;
      req_chan.reg_index  <= RegOutEnable;
      req_chan.write_data <= '0;
      req_chan.pin_levels <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: data read paths, every pin kind, clear-on-write bits, unused code.
      send_request(bus_request(ReqRead,   RegControl,   '0,            '0));
      send_request(bus_request(ReqWrite,  RegOutEnable, 32'hFFFF_0000, '0));
      send_request(bus_request(ReqWrite,  RegInEnable,  32'h00FF_FF00, '0));
      send_request(bus_request(ReqWrite,  RegData,      32'hA5A5_A5A5, '0));
      send_request(bus_request(ReqRead,   RegData,      '0,            32'hFFFF_FFFF));
      send_request(bus_request(ReqRead,   RegData,      '1,            32'h0000_0000));
      send_request(bus_request(ReqWrite,  RegTypeLower, 32'hE4E4_E4E4, '0));
      send_request(bus_request(ReqWrite,  RegTypeUpper, 32'h1B1B_1B1B, '0));
      send_request(bus_request(ReqWrite,  RegMask,      32'hFFFF_FFFF, '0));
      send_request(bus_request(ReqWrite,  RegControl,   32'hFFFF_FFFF, '0));
      send_request(bus_request(ReqSample, RegData,      '0,            32'h0000_0000));
      send_request(bus_request(ReqSample, RegData,      '0,            32'hFFFF_FFFF));
      send_request(bus_request(ReqSample, RegData,      '0,            32'h0000_0000));
      send_request(bus_request(ReqRead,   RegPending,   '0,            '0));
      send_request(bus_request(ReqRead,   RegControl,   '0,            '0));
      send_request(bus_request(ReqWrite,  RegPending,   32'hFFFF_FFFF, '0));
      send_request(bus_request(ReqWrite,  RegControl,   32'h0000_0003, '0));
      send_request(bus_request(ReqRead,   RegControl,   '0,            '0));
      send_request(bus_request(ReqUnused, RegData,      32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(bus_request(ReqWrite,  RegMask,      32'h0000_0000, '0));
      send_request(bus_request(ReqSample, RegData,      '0,            32'hFFFF_FFFF));
      send_request(bus_request(ReqRead,   RegTypeUpper, '0,            '0));
      send_request(bus_request(ReqRead,   RegTypeLower, '0,            '0));
      send_request(bus_request(ReqRead,   RegInEnable,  '0,            '0));
      send_request(bus_request(ReqWrite,  RegControl,   32'h0000_0000, '0));

      for (int n = 0; n < RandomItems; n++) begin
         // Hold the result side off while requests keep coming, so the core backs up.
         if (n == HoldAt) begin
            holds_asked <= holds_asked + 1;
            steady_left = HoldItems;
         end
         if (n == DrainAt) drain_results();
         send_request(make_random_request());
         if (steady_left > 0) begin
            steady_left--;
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            idle_cycles($urandom_range(1, 8));
         end else begin
            burst_left--;
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      while (tracker.awaited.size() != 0) begin
         void'(tracker.awaited.pop_front());
         tracker.report("result never arrived");
      end
      if (tracker.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
